// ===== rtl/core/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;

  localparam int STEP_W = 6;

  typedef logic [STEP_W-1:0] swm_step_t;

  localparam swm_step_t STEP_IDLE    = 6'd0;
  localparam swm_step_t STEP_CLK_UP  = 6'd1;
  localparam swm_step_t STEP_CS_DOWN = 6'd2;
  localparam swm_step_t STEP_BYTE0   = 6'd3;
  localparam swm_step_t STEP_GAP     = 6'd27;
  localparam swm_step_t STEP_BYTE1   = 6'd28;
  localparam swm_step_t STEP_CS_UP   = 6'd52;

  // position inside a bit: drive data, clock low, clock high; none outside bits
  typedef enum logic [1:0] {
    SUB_DRIVE  = 2'd0,
    SUB_CLK_LO = 2'd1,
    SUB_CLK_HI = 2'd2,
    SUB_NONE   = 2'd3
  } swm_sub_t;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd300;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_HALF_PERIOD = 1'b0;

  localparam int IN_DW  = 24;
  localparam int OUT_DW = 24;
  localparam int RX_W   = 15;

  // result item bit positions
  localparam int OB_SCLK = 0;
  localparam int OB_MOSI = 1;
  localparam int OB_CS_N = 2;
  localparam int OB_BUSY = 3;
  localparam int OB_DONE = 4;
  localparam int OB_RX   = 5;

  typedef struct packed {
    logic sclk;
    logic mosi;
    logic cs_n;
  } swm_pins_t;

endpackage
`default_nettype wire

// ===== rtl/core/spi_word_master.sv =====
// SPI master, mode 3, sending one 16-bit word MSB first and collecting the
// 16 bits returned. Each input item is one tick of the pin waveform and one
// result item (pin levels, busy, done, received word) comes back for it; an
// item is taken every clock unless an unread result item is held in the
// output register, a single register decoupling the two sides. A transfer
// started by an item with tuser high runs 1 + 1 + 48 + 1 + 1 = 52 phases
// of half_period ticks each (one phase counter and one tick counter set
// the figure); the received word shifted right by one appears on the done
// tick, and start requests while busy are dropped. half_period is written
// over the APB port at byte address 0; a value of zero acts as one.
`timescale 1ns / 1ps
`default_nettype none
module spi_word_master (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  // [15:0] tx_word, [16] miso, [23:17] zero
  input  wire  [swm_pkg::IN_DW-1:0]   in_tdata,
  // [0] func
  input  wire                         in_tuser,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // [0] sclk, [1] mosi, [2] cs_n, [3] busy_res, [4] done_res,
  // [19:5] rx_word, [23:20] zero
  output logic [swm_pkg::OUT_DW-1:0]  out_tdata,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [swm_pkg::CFG_AW-1:0]  paddr,
  input  wire  [swm_pkg::CFG_DW-1:0]  pwdata,
  output logic [swm_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import swm_pkg::*;

  logic [15:0] half_period_r;
  swm_step_t   step_r, step_nxt;
  swm_sub_t    sub_r, sub_nxt;
  logic [15:0] dcnt_r, dcnt_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] send_r, send_nxt;
  logic [15:0] recv_r, recv_nxt;
  swm_pins_t   pins_r, pins_nxt;
  logic        out_valid_r;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;

  logic        accept;
  logic [15:0] hp;
  logic [15:0] dcnt_inc;
  logic        busy, done;
  logic [RX_W-1:0] rx;
  logic        func, miso;
  logic [15:0] tx_word;
  swm_step_t   step_cur, step_inc;
  swm_sub_t    sub_cur;

  assign pready    = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign func      = in_tuser;
  assign tx_word   = in_tdata[15:0];
  assign miso      = in_tdata[16];
  assign hp        = (half_period_r == 16'd0) ? 16'd1 : half_period_r;
  assign prdata    = (paddr[2] == REG_HALF_PERIOD) ? {16'd0, half_period_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_PERIOD) begin
      half_period_r <= pwdata[15:0];
    end
  end

  always_comb begin
    step_nxt = step_r;
    sub_nxt  = sub_r;
    dcnt_nxt = dcnt_r;
    bit_nxt  = bit_r;
    send_nxt = send_r;
    recv_nxt = recv_r;
    pins_nxt = pins_r;
    busy     = 1'b0;
    done     = 1'b0;
    rx       = '0;
    step_inc = step_r + 6'd1;
    dcnt_inc = 16'd0;

    if (step_r == STEP_IDLE && func) begin
      send_nxt = tx_word;
      recv_nxt = 16'd0;
      bit_nxt  = 4'd0;
      dcnt_nxt = 16'd0;
      step_nxt = STEP_CLK_UP;
      sub_nxt  = SUB_NONE;
    end
    step_cur = step_nxt;
    sub_cur  = sub_nxt;

    if (step_cur != STEP_IDLE) begin
      busy = 1'b1;
      if (dcnt_nxt == 16'd0) begin
        if (step_cur == STEP_CLK_UP) begin
          pins_nxt.sclk = 1'b1;
        end else if (step_cur == STEP_CS_DOWN) begin
          pins_nxt.cs_n = 1'b0;
        end else if (step_cur == STEP_CS_UP) begin
          pins_nxt.cs_n = 1'b1;
        end else begin
          unique case (sub_cur)
            SUB_DRIVE:  pins_nxt.mosi = send_nxt[4'd15 - bit_nxt];
            SUB_CLK_LO: pins_nxt.sclk = 1'b0;
            SUB_CLK_HI: pins_nxt.sclk = 1'b1;
            SUB_NONE:   ;
          endcase
        end
      end
      dcnt_inc = dcnt_nxt + 16'd1;
      if (dcnt_inc >= hp || dcnt_inc == 16'd0) begin
        dcnt_nxt = 16'd0;
        if (sub_cur == SUB_CLK_HI) begin
          recv_nxt = {recv_nxt[14:0], miso};
          bit_nxt  = bit_nxt + 4'd1;
        end
        step_inc = step_cur + 6'd1;
        if (step_cur == STEP_CS_UP) begin
          done     = 1'b1;
          rx       = recv_nxt[15:1];
          step_nxt = STEP_IDLE;
          sub_nxt  = SUB_NONE;
        end else begin
          step_nxt = step_inc;
          if (step_inc == STEP_BYTE0 || step_inc == STEP_BYTE1) begin
            sub_nxt = SUB_DRIVE;
          end else if (step_inc == STEP_GAP || step_inc == STEP_CS_UP) begin
            sub_nxt = SUB_NONE;
          end else begin
            unique case (sub_cur)
              SUB_DRIVE:  sub_nxt = SUB_CLK_LO;
              SUB_CLK_LO: sub_nxt = SUB_CLK_HI;
              SUB_CLK_HI: sub_nxt = SUB_DRIVE;
              SUB_NONE:   sub_nxt = SUB_NONE;
            endcase
          end
        end
      end else begin
        dcnt_nxt = dcnt_inc;
      end
    end

    out_data_nxt          = '0;
    out_data_nxt[OB_SCLK] = pins_nxt.sclk;
    out_data_nxt[OB_MOSI] = pins_nxt.mosi;
    out_data_nxt[OB_CS_N] = pins_nxt.cs_n;
    out_data_nxt[OB_BUSY] = busy;
    out_data_nxt[OB_DONE] = done;
    out_data_nxt[OB_RX +: RX_W] = rx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      sub_r       <= SUB_NONE;
      dcnt_r      <= 16'd0;
      bit_r       <= 4'd0;
      send_r      <= 16'd0;
      recv_r      <= 16'd0;
      pins_r      <= '{sclk: 1'b1, mosi: 1'b0, cs_n: 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        step_r <= step_nxt;
        sub_r  <= sub_nxt;
        dcnt_r <= dcnt_nxt;
        bit_r  <= bit_nxt;
        send_r <= send_nxt;
        recv_r <= recv_nxt;
        pins_r <= pins_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/swm_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swm_chk (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        out_tvalid,
  input wire                        out_tready,
  input wire [swm_pkg::OUT_DW-1:0]  out_tdata
);
  import swm_pkg::*;

  // a done item belongs to the transfer
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OB_DONE] |-> out_tdata[OB_BUSY])
    else $error("done without busy");

  // received word only shown with done
  a_rx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OB_DONE] |-> out_tdata[OB_RX +: RX_W] == '0)
    else $error("rx word outside done");

  // select low only inside a transfer
  a_cs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OB_CS_N] |-> out_tdata[OB_BUSY])
    else $error("cs_n low while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled item changed");

endmodule

bind spi_word_master swm_chk u_swm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== verif/spi_word_master_checker.sv =====
`timescale 1ns / 1ps
module spi_word_master_checker
  import swm_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  input  wire                 in_tready,
  input  wire  [IN_DW-1:0]    in_tdata,
  input  wire                 in_tuser,
  input  wire                 out_tvalid,
  input  wire                 out_tready,
  input  wire  [OUT_DW-1:0]   out_tdata,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [CFG_AW-1:0]   paddr,
  input  wire  [CFG_DW-1:0]   pwdata,
  input  wire                 pready,
  output int                  mismatches,
  output int                  outstanding,
  output int                  words_done,
  output logic                xfer_busy
);

  localparam logic [CFG_AW-1:0] HP_ADDR = CFG_AW'(4 * int'(REG_HALF_PERIOD));

  typedef struct packed {
    logic [RX_W-1:0] rx;
    logic            done;
    logic            busy;
    logic            cs_n;
    logic            mosi;
    logic            sclk;
  } wave_t;

  wave_t       wave_due[$];
  logic [15:0] half_period;
  swm_step_t   step;
  logic [15:0] dly;
  logic [3:0]  bit_idx;
  logic [15:0] tx_shift;
  logic [15:0] rx_shift;
  swm_pins_t   pins;
  int          err_n;
  int          done_n;

  function swm_sub_t sub_of(input swm_step_t s);
    int k;
    k = int'(s);
    if (s >= STEP_BYTE0 && s < STEP_GAP) return swm_sub_t'(2'((k - int'(STEP_BYTE0)) % 3));
    if (s >= STEP_BYTE1 && s < STEP_CS_UP) return swm_sub_t'(2'((k - int'(STEP_BYTE1)) % 3));
    return SUB_NONE;
  endfunction

  task enter_phase;
    if (step == STEP_CLK_UP) begin
      pins.sclk = 1'b1;
    end else if (step == STEP_CS_DOWN) begin
      pins.cs_n = 1'b0;
    end else if (step == STEP_CS_UP) begin
      pins.cs_n = 1'b1;
    end else begin
      case (sub_of(step))
        SUB_DRIVE:  pins.mosi = tx_shift[4'd15 - bit_idx];
        SUB_CLK_LO: pins.sclk = 1'b0;
        SUB_CLK_HI: pins.sclk = 1'b1;
        default: ;
      endcase
    end
  endtask

  // one tick of the bit-banged waveform
  task bang_tick(input logic start, input logic [15:0] word, input logic sdi, output wave_t r);
    logic [15:0] hp;
    hp = (half_period == 16'd0) ? 16'd1 : half_period;
    r = '0;
    if (step > STEP_CS_UP) step = STEP_IDLE;
    if (step == STEP_IDLE && start) begin
      tx_shift = word;
      rx_shift = '0;
      bit_idx  = '0;
      dly      = '0;
      step     = STEP_CLK_UP;
    end
    if (step != STEP_IDLE) begin
      r.busy = 1'b1;
      if (dly == 16'd0) enter_phase();
      dly = dly + 16'd1;
      if (dly >= hp || dly == 16'd0) begin
        dly = '0;
        if (sub_of(step) == SUB_CLK_HI) begin
          rx_shift = {rx_shift[14:0], sdi};
          bit_idx  = bit_idx + 4'd1;
        end
        if (step == STEP_CS_UP) begin
          r.done = 1'b1;
          r.rx   = rx_shift[15:1];
          step   = STEP_IDLE;
        end else begin
          step = step + 6'd1;
        end
      end
    end
    r.sclk = pins.sclk;
    r.mosi = pins.mosi;
    r.cs_n = pins.cs_n;
  endtask

  always @(posedge clk) begin
    wave_t want;
    wave_t got;
    logic  pad_bad;
    if (!rst_n) begin
      half_period = HALF_PERIOD_RST;
      step        = STEP_IDLE;
      dly         = '0;
      bit_idx     = '0;
      tx_shift    = '0;
      rx_shift    = '0;
      pins        = '{sclk: 1'b1, mosi: 1'b0, cs_n: 1'b1};
      err_n       = 0;
      done_n      = 0;
      wave_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == HP_ADDR) half_period = pwdata[15:0];
      if (in_tvalid && in_tready) begin
        bang_tick(in_tuser, in_tdata[15:0], in_tdata[16], want);
        wave_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.sclk = out_tdata[OB_SCLK];
        got.mosi = out_tdata[OB_MOSI];
        got.cs_n = out_tdata[OB_CS_N];
        got.busy = out_tdata[OB_BUSY];
        got.done = out_tdata[OB_DONE];
        got.rx   = out_tdata[OB_RX +: RX_W];
        pad_bad  = out_tdata[OUT_DW-1:OB_RX+RX_W] !== '0;
        if (wave_due.size() == 0) begin
          err_n++;
          if (err_n <= 10) $display("unexpected result item %h", out_tdata);
        end else begin
          want = wave_due.pop_front();
          if (want.done) done_n++;
          if (got !== want || pad_bad) begin
            err_n++;
            if (err_n <= 10)
              $display({"mismatch: sclk %b/%b mosi %b/%b cs_n %b/%b busy %b/%b ",
                        "done %b/%b rx %h/%h pad %b (exp/got)"},
                       want.sclk, got.sclk, want.mosi, got.mosi, want.cs_n, got.cs_n,
                       want.busy, got.busy, want.done, got.done, want.rx, got.rx, pad_bad);
          end
        end
      end
    end
    mismatches  <= err_n;
    outstanding <= wave_due.size();
    words_done  <= done_n;
    xfer_busy   <= (step != STEP_IDLE);
  end

endmodule

// ===== verif/spi_word_master_test.sv =====
`timescale 1ns / 1ps
module spi_word_master_test;
  import swm_pkg::*;

  localparam int WATCH_LIMIT = 2000;
  localparam logic [CFG_AW-1:0] HP_ADDR = CFG_AW'(4 * int'(REG_HALF_PERIOD));

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [IN_DW-1:0]  in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tready = 1'b1;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [CFG_DW-1:0] pwdata     = '0;
  wire               in_tready;
  wire               out_tvalid;
  wire  [OUT_DW-1:0] out_tdata;
  wire  [CFG_DW-1:0] prdata;
  wire               pready;

  int   mismatches;
  int   outstanding;
  int   words_done;
  logic xfer_busy;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   ticks_sent = 0;
  int   quiet      = 0;

  spi_word_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  spi_word_master_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .words_done (words_done),
    .xfer_busy  (xfer_busy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("spi_word_master test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_tick(input logic start, input logic [15:0] word, input logic sdi);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= IN_DW'({sdi, word});
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // plain ticks until the transfer in flight has finished
  task automatic settle;
    drain();
    while (xfer_busy) begin
      repeat (16) push_tick(1'b0, 16'($urandom), 1'($urandom_range(1)));
      drain();
    end
  endtask

  task automatic write_half_period(input logic [15:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= HP_ADDR;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    logic [15:0] word;
    repeat (n) begin
      case ($urandom_range(7))
        0:       word = 16'h0000;
        1:       word = 16'hFFFF;
        default: word = 16'($urandom);
      endcase
      push_tick($urandom_range(7) == 0, word, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero half_period acts as one; start held high through busy and done ticks
    write_half_period(16'd0);
    push_tick(1'b1, 16'hFFFF, 1'b1);
    repeat (51) push_tick(1'b1, 16'h0000, 1'b1);
    push_tick(1'b1, 16'h0000, 1'b0);
    repeat (51) push_tick(1'b0, 16'hFFFF, 1'b0);
    settle();

    // half_period changes may land in the middle of a transfer
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 79; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 79; end
        default: begin idle_pct = 27; stall_pct <= 27; end
      endcase
      write_half_period(16'd1);
      run_random(75);
      drain();
      write_half_period(16'd2);
      run_random(75);
      drain();
      write_half_period(16'($urandom_range(8, 3)));
      run_random(75);
      drain();
    end

    // longest phase: only the opening of one transfer fits
    write_half_period(16'hFFFF);
    push_tick(1'b1, 16'h5AC3, 1'b1);
    run_random(200);
    drain();
    repeat (10) @(posedge clk);

    $display("%0d ticks driven under four flow-control mixes, %0d transfers completed",
             ticks_sent, words_done);
    $display("half_period covered 0, 1, 2, short random values and 65535");
    if (mismatches == 0 && outstanding == 0) begin
      $display("spi_word_master test passed");
    end else begin
      $display("spi_word_master test failed");
    end
    $finish;
  end

endmodule
